// ===== hw/rtl/multitap_feedback_delay_defines.svh =====
// assertion macros shared by the delay line checker
`ifndef MULTITAP_FEEDBACK_DELAY_DEFINES_SVH
`define MULTITAP_FEEDBACK_DELAY_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define MTFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define MTFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mtfd_pkg.sv =====
// shared constants, types and arithmetic helpers for the multitap feedback delay
package mtfd_pkg;

  // delay memory geometry
  localparam int DELAY_DEPTH = 16384;
  localparam int IDX_W       = $clog2(DELAY_DEPTH);

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int TAPLEN_W   = 14;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // effective tap length must hold both the register range and the memory depth
  localparam int DEPTH_LEN_W = $clog2(DELAY_DEPTH + 1);
  localparam int LEN_W       = (TAPLEN_W > DEPTH_LEN_W) ? TAPLEN_W : DEPTH_LEN_W;

  // tap geometry
  localparam int TAP_MIN        = 1001;
  localparam int TAP_TWO_OFFSET = 1000;

  // divide by three as multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = LEN_W + 2;
  localparam int RECIP3      = (2 ** RECIP_SHIFT + 2) / 3;
  localparam int THIRD_W     = LEN_W + RECIP_SHIFT;

  // q1.15 scaling
  localparam int Q15_FRAC  = 15;
  localparam int Q15_BIAS  = 2 ** Q15_FRAC - 1;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int Q_W       = PROD_W - Q15_FRAC;

  // register reset values
  localparam logic [GAIN_W-1:0]   INPUT_GAIN_RST    = 16'd32768;
  localparam logic [GAIN_W-1:0]   MIX_GAIN_RST      = 16'd0;
  localparam logic [GAIN_W-1:0]   FEEDBACK_GAIN_RST = 16'd0;
  localparam logic [TAPLEN_W-1:0] TAP_LENGTH_RST    = 14'd11098;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INPUT_GAIN    = 3'd0,
    REG_MIX_GAIN      = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_TAP_LENGTH    = 3'd3
  } reg_idx_t;

  // sequencer states, one memory access slot each
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRY,
    ST_TAP1,
    ST_TAP3,
    ST_TAP2,
    ST_FB1,
    ST_FB1_WR,
    ST_FB2,
    ST_FB2_WR
  } state_t;

  // product / 32768 truncated toward zero, saturated to a sample
  function automatic logic signed [SAMPLE_W-1:0] scale_q15(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0]   biased;
    logic        [Q_W-1:0]      q;
    logic signed [SAMPLE_W-1:0] res;
    biased = p[PROD_W-1] ? p + PROD_W'(Q15_BIAS) : p;
    q      = biased[PROD_W-1:Q15_FRAC];
    if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
      res = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

  // address of the sample written k steps ago, one ahead of the write pointer
  function automatic logic [IDX_W-1:0] tap_addr(
    input logic [IDX_W-1:0] wp,
    input logic [LEN_W-1:0] k
  );
    logic [LEN_W:0] t;
    t = (LEN_W+1)'(wp) + (LEN_W+1)'(DELAY_DEPTH + 1) - (LEN_W+1)'(k);
    if (t >= (LEN_W+1)'(DELAY_DEPTH)) begin
      t = t - (LEN_W+1)'(DELAY_DEPTH);
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/mtfd_if.sv =====
// valid/ready channel interfaces for sample requests, results and register writes
interface mtfd_in_if;
  import mtfd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] dry_sample;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  modport source(output valid, dry_sample, left_in, right_in, input ready);
  modport sink(input valid, dry_sample, left_in, right_in, output ready);
endinterface

interface mtfd_out_if;
  import mtfd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  modport source(output valid, left_out, right_out, input ready);
  modport sink(input valid, left_out, right_out, output ready);
endinterface

interface mtfd_cfg_if;
  import mtfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/mtfd_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
module mtfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/multitap_feedback_delay.sv =====
// top level of the three-tap feedback delay line with one shared delay memory
//
//   channel   dir   handshake       payload
//   in_ch     in    valid / ready   dry_sample, left_in, right_in (signed 16)
//   out_ch    out   valid / ready   left_out, right_out (signed 16)
//   cfg_ch    in    valid / ready   addr (3), data (16); ready is always high
//
// requests are sequenced: the delay memory has one write and one read
// port, and three tap reads plus three writes are spread over an 8-state sequencer
// that also time-shares one 16x17 multiplier. the next request is taken in the
// last cycle of the current one. after reset a clearing pass zeroes the memory,
// during which no request is taken. a full result register that is not taken
// holds the sequencer in its last state.
module multitap_feedback_delay (
  input  logic        clk,
  input  logic        rst_n,
  mtfd_in_if.sink     in_ch,
  mtfd_out_if.source  out_ch,
  mtfd_cfg_if.sink    cfg_ch
);
  import mtfd_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]   input_gain_r;
  logic [GAIN_W-1:0]   mix_gain_r;
  logic [GAIN_W-1:0]   feedback_gain_r;
  logic [TAPLEN_W-1:0] tap_length_r;

  // tap delays derived from the length register
  logic [LEN_W-1:0]   len_lo;
  logic [LEN_W-1:0]   len_eff;
  logic [THIRD_W-1:0] third_prod;
  logic [LEN_W-1:0]   third;
  logic [LEN_W-1:0]   k1_r;
  logic [LEN_W-1:0]   k2_r;
  logic [LEN_W-1:0]   k3_r;

  // control state
  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] wp_r;
  logic             out_valid_r;

  // per-request registers
  logic signed [SAMPLE_W-1:0] dry_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [SAMPLE_W-1:0] b_r;
  logic signed [SAMPLE_W-1:0] c_r;
  logic signed [SAMPLE_W-1:0] newb_r;
  logic signed [SAMPLE_W-1:0] left_acc_r;
  logic signed [SAMPLE_W-1:0] right_acc_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;
  logic signed [PROD_W-1:0]   prod_r;

  // datapath wires
  logic [IDX_W-1:0]           o1;
  logic [IDX_W-1:0]           o2;
  logic [IDX_W-1:0]           o3;
  logic signed [SAMPLE_W-1:0] sc;
  logic signed [SAMPLE_W-1:0] rd_s;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [SAMPLE_W-1:0] mul_x;
  logic [GAIN_W-1:0]          mul_g;
  logic signed [GAIN_W:0]     mul_g_s;
  logic                       in_rdy;
  logic                       in_acc;
  logic                       finish;

  // memory port signals
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  mtfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_gain_r    <= INPUT_GAIN_RST;
      mix_gain_r      <= MIX_GAIN_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      tap_length_r    <= TAP_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_INPUT_GAIN:    input_gain_r    <= cfg_ch.data[GAIN_W-1:0];
        REG_MIX_GAIN:      mix_gain_r      <= cfg_ch.data[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_ch.data[GAIN_W-1:0];
        REG_TAP_LENGTH:    tap_length_r    <= cfg_ch.data[TAPLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the length, then tap two and tap three delays
  always_comb begin
    len_lo = (LEN_W'(tap_length_r) < LEN_W'(TAP_MIN)) ? LEN_W'(TAP_MIN)
                                                       : LEN_W'(tap_length_r);
    len_eff = (len_lo > LEN_W'(DELAY_DEPTH)) ? LEN_W'(DELAY_DEPTH) : len_lo;
    third_prod = THIRD_W'(len_eff) * THIRD_W'(RECIP3);
    third = third_prod[THIRD_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    k1_r <= len_eff;
    k2_r <= len_eff - LEN_W'(TAP_TWO_OFFSET);
    k3_r <= {third[LEN_W-2:0], 1'b0};
  end

  // tap addresses relative to the write pointer
  assign o1 = tap_addr(wp_r, k1_r);
  assign o2 = tap_addr(wp_r, k2_r);
  assign o3 = tap_addr(wp_r, k3_r);

  assign sc   = scale_q15(prod_r);
  assign rd_s = $signed(ram_rdata);
  // write location after the first feedback, which may have landed on it
  assign base = (o2 == wp_r) ? newb_r : s_r;

  assign finish = (state_r == ST_FB2_WR) && (!out_valid_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == IDX_W'(DELAY_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DRY;
      end
      ST_DRY:    state_nxt = ST_TAP1;
      ST_TAP1:   state_nxt = ST_TAP3;
      ST_TAP3:   state_nxt = ST_TAP2;
      ST_TAP2:   state_nxt = ST_FB1;
      ST_FB1:    state_nxt = ST_FB1_WR;
      ST_FB1_WR: state_nxt = ST_FB2;
      ST_FB2:    state_nxt = ST_FB2_WR;
      ST_FB2_WR: begin
        if (finish) state_nxt = in_acc ? ST_DRY : ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // memory, multiplier and handshake control per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = '0;
    ram_raddr = o1;
    mul_x     = dry_r;
    mul_g     = input_gain_r;
    in_rdy    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_rdy = 1'b1;
      end
      ST_DRY: begin
        ram_raddr = o1;
      end
      ST_TAP1: begin
        ram_we    = 1'b1;
        ram_wdata = sc;
        ram_raddr = o3;
        mul_x     = rd_s;
        mul_g     = mix_gain_r;
      end
      ST_TAP3: begin
        ram_raddr = o2;
        mul_x     = rd_s;
        mul_g     = mix_gain_r;
      end
      ST_TAP2: begin
        mul_x = rd_s;
        mul_g = mix_gain_r;
      end
      ST_FB1: begin
        mul_x = a_r;
        mul_g = feedback_gain_r;
      end
      ST_FB1_WR: begin
        ram_we    = 1'b1;
        ram_waddr = o2;
        ram_wdata = b_r + sc;
      end
      ST_FB2: begin
        // tap three sees the first feedback when both land on one entry
        mul_x = (o3 == o2) ? newb_r : c_r;
        mul_g = feedback_gain_r;
      end
      ST_FB2_WR: begin
        // keep the feedback product steady while the result register is full
        mul_x     = (o3 == o2) ? newb_r : c_r;
        mul_g     = feedback_gain_r;
        ram_we    = finish;
        ram_wdata = base + sc;
        in_rdy    = finish;
      end
      default: ;
    endcase
  end

  // shared multiplier with registered product
  assign mul_g_s = {1'b0, mul_g};

  always_ff @(posedge clk) begin
    prod_r <= mul_x * mul_g_s;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (finish) begin
        wp_r <= (wp_r == IDX_W'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and per-step datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r   <= in_ch.dry_sample;
      left_r  <= in_ch.left_in;
      right_r <= in_ch.right_in;
    end
    case (state_r)
      ST_TAP1: begin
        s_r <= sc;
        a_r <= rd_s;
      end
      ST_TAP3: begin
        c_r        <= rd_s;
        left_acc_r <= left_r + sc;
      end
      ST_TAP2: begin
        b_r        <= rd_s;
        left_acc_r <= left_acc_r + sc;
      end
      ST_FB1: begin
        right_acc_r <= right_r + sc;
      end
      ST_FB1_WR: begin
        newb_r <= b_r + sc;
      end
      default: ;
    endcase
    if (finish) begin
      out_left_r  <= left_acc_r;
      out_right_r <= right_acc_r;
    end
  end

  // result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;

endmodule

// ===== hw/rtl/mtfd_checker.sv =====
// port-level checker for the multitap feedback delay and its bind
`include "multitap_feedback_delay_defines.svh"

module mtfd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mtfd_pkg::SAMPLE_W-1:0] out_left,
  input logic signed [mtfd_pkg::SAMPLE_W-1:0] out_right
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // reset empties the result register
  `MTFD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid survived reset")

  // a stalled result keeps its value
  `MTFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right), "stalled result changed")

  // no request is taken while another request occupies the sequencer
  `MTFD_ASSERT(a_in_spacing, in_acc |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready, "request taken inside another request")

  // a fresh result appears only after a matching request
  `MTFD_ASSERT(a_out_latency, $rose(out_valid) |-> $past(in_acc, 9), "result without matching request")

endmodule

bind multitap_feedback_delay mtfd_checker u_mtfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_out),
  .out_right (out_ch.right_out)
);

// ===== bench/multitap_feedback_delay_tb.sv =====
// self-checking bench for the three-tap feedback delay line with a shadow memory predictor
`timescale 1ns / 100ps

module multitap_feedback_delay_tb;
  import mtfd_pkg::*;

  // bench timing and limits
  localparam int CLK_HALF      = 10;
  localparam int RST_CYCLES    = 5;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int GAP_PERCENT   = 33;
  localparam int MAX_REPORTS   = 10;

  // tap three sits at two thirds of the tap length
  localparam int TAP_THREE_DIV = 3;
  localparam int TAP_THREE_MUL = 2;

  // register indexes past the last register, writes there are dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

  // tap lengths at which tap two and tap three share one location
  localparam int OVERLAP_LEN_LO = 2996;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } delay_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_mix;
    logic signed [SAMPLE_W-1:0] right_mix;
  } mix_pair_t;

  logic clk;
  logic rst_n;

  mtfd_in_if  in_ch();
  mtfd_out_if out_ch();
  mtfd_cfg_if cfg_ch();

  multitap_feedback_delay dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block's registers and delay memory
  logic [GAIN_W-1:0]          in_gain_reg;
  logic [GAIN_W-1:0]          mix_gain_reg;
  logic [GAIN_W-1:0]          fb_gain_reg;
  logic [TAPLEN_W-1:0]        tap_len_reg;
  logic signed [SAMPLE_W-1:0] delay_img [DELAY_DEPTH];
  int unsigned                wr_ptr;

  // request and result bookkeeping
  delay_req_t pending_req [$];
  mix_pair_t  expected_mix [$];
  delay_req_t next_req;
  mix_pair_t  got_mix;
  mix_pair_t  want_mix;
  int         unaccepted_cnt;
  int         mismatch_cnt;
  int         cycle_cnt;
  bit         in_taken;
  bit         in_gaps;
  bit         out_gaps;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // q1.15 scale, truncated toward zero and saturated to a sample
  function automatic logic signed [SAMPLE_W-1:0] q15_scale(input int x, input int unsigned g);
    longint prod;
    prod = (longint'(x) * longint'(g)) / 32768;
    if (prod > 32767) begin
      prod = 32767;
    end else if (prod < -32768) begin
      prod = -32768;
    end
    return prod[SAMPLE_W-1:0];
  endfunction

  // memory location of the sample written k steps ago
  function automatic int unsigned loc_behind(input int unsigned k);
    int unsigned t;
    t = wr_ptr + 1 + DELAY_DEPTH - k;
    if (t >= DELAY_DEPTH) t -= DELAY_DEPTH;
    return t;
  endfunction

  // one delay step on the shadow memory, returns the mixed left and right
  function automatic mix_pair_t run_delay_step(input logic signed [SAMPLE_W-1:0] dry,
                                               input logic signed [SAMPLE_W-1:0] left,
                                               input logic signed [SAMPLE_W-1:0] right);
    int unsigned eff_len;
    int unsigned loc1;
    int unsigned loc2;
    int unsigned loc3;
    mix_pair_t   res;
    eff_len = tap_len_reg;
    if (eff_len < TAP_MIN) eff_len = TAP_MIN;
    if (eff_len > DELAY_DEPTH) eff_len = DELAY_DEPTH;
    delay_img[wr_ptr] = q15_scale(dry, in_gain_reg);
    loc1 = loc_behind(eff_len);
    loc2 = loc_behind(eff_len - TAP_TWO_OFFSET);
    loc3 = loc_behind(eff_len / TAP_THREE_DIV * TAP_THREE_MUL);
    // 16-bit sums wrap
    res.left_mix  = left + q15_scale(delay_img[loc1], mix_gain_reg)
                         + q15_scale(delay_img[loc3], mix_gain_reg);
    res.right_mix = right + q15_scale(delay_img[loc2], mix_gain_reg);
    // feedback: tap one into tap two, then tap three into the write location
    delay_img[loc2]   = delay_img[loc2] + q15_scale(delay_img[loc1], fb_gain_reg);
    delay_img[wr_ptr] = delay_img[wr_ptr] + q15_scale(delay_img[loc3], fb_gain_reg);
    wr_ptr = (wr_ptr == DELAY_DEPTH - 1) ? 0 : wr_ptr + 1;
    return res;
  endfunction

  function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] dry,
                                       input logic signed [SAMPLE_W-1:0] left,
                                       input logic signed [SAMPLE_W-1:0] right);
    delay_req_t r;
    r.dry   = dry;
    r.left  = left;
    r.right = right;
    pending_req.push_back(r);
    unaccepted_cnt++;
  endfunction

  // random sample, leaning on the extremes now and then
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 16'sh8000;
      1: s = 16'sh7fff;
      2: s = '0;
      3: s = '1;
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // register write, mirrored into the shadow copy on the handshake
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_INPUT_GAIN:    in_gain_reg  = val;
      REG_MIX_GAIN:      mix_gain_reg = val;
      REG_FEEDBACK_GAIN: fb_gain_reg  = val;
      REG_TAP_LENGTH:    tap_len_reg  = val[TAPLEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_random_gains();
    cfg_write(REG_INPUT_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(REG_MIX_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(REG_FEEDBACK_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  // hold off until every request is taken and every result is back
  task automatic settle();
    do @(negedge clk); while (unaccepted_cnt != 0 || expected_mix.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken <= 1'b0;
      if (pending_req.size() != 0 && !(in_gaps && $urandom_range(0, 99) < GAP_PERCENT)) begin
        next_req = pending_req.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.dry_sample <= next_req.dry;
        in_ch.left_in    <= next_req.left;
        in_ch.right_in   <= next_req.right;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // request accepted: predict its result
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_mix.push_back(run_delay_step(in_ch.dry_sample, in_ch.left_in, in_ch.right_in));
      unaccepted_cnt--;
      in_taken <= 1'b1;
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(out_gaps && $urandom_range(0, 99) < GAP_PERCENT);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_mix.left_mix  = out_ch.left_out;
      got_mix.right_mix = out_ch.right_out;
      if (expected_mix.size() == 0) begin
        note_mismatch("unexpected result, left_out", 0, got_mix.left_mix);
      end else begin
        want_mix = expected_mix.pop_front();
        if (got_mix.left_mix !== want_mix.left_mix) begin
          note_mismatch("left_out", want_mix.left_mix, got_mix.left_mix);
        end
        if (got_mix.right_mix !== want_mix.right_mix) begin
          note_mismatch("right_out", want_mix.right_mix, got_mix.right_mix);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int chunk_len [3];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.dry_sample = '0;
    in_ch.left_in    = '0;
    in_ch.right_in   = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.addr      = '0;
    cfg_ch.data      = '0;
    in_taken         = 1'b0;
    in_gaps          = 1'b1;
    out_gaps         = 1'b1;
    unaccepted_cnt   = 0;
    mismatch_cnt     = 0;
    cycle_cnt        = 0;
    in_gain_reg      = INPUT_GAIN_RST;
    mix_gain_reg     = MIX_GAIN_RST;
    fb_gain_reg      = FEEDBACK_GAIN_RST;
    tap_len_reg      = TAP_LENGTH_RST;
    wr_ptr           = 0;
    foreach (delay_img[i]) delay_img[i] = '0;
    chunk_len = '{60, 60, 50};

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: outputs pass the inputs through
    queue_sample(16'sh1234, 16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, -16'sd5, 16'sd77);
    settle();

    // full-scale gains, too short a tap length, writes to unused indexes
    cfg_write(REG_INPUT_GAIN, 16'hffff);
    cfg_write(REG_MIX_GAIN, 16'hffff);
    cfg_write(REG_FEEDBACK_GAIN, 16'hffff);
    cfg_write(REG_TAP_LENGTH, 16'h0000);
    cfg_write(REG_SPARE_FIRST, 16'h5a5a);
    cfg_write(REG_SPARE_LAST, 16'ha5a5);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample('0, '0, '0);
    queue_sample('1, 16'sh7fff, 16'sh8000);
    queue_sample(16'sd1, 16'sh8000, 16'sh7fff);
    queue_sample(16'sh7fff, '1, '0);
    queue_sample(16'sh8000, '0, '1);
    queue_sample(16'sh4000, 16'sh4000, 16'sh4000);
    queue_sample(16'shc000, 16'shc000, 16'shc000);
    queue_sample(16'sh5555, 16'shaaaa, 16'sh5555);
    queue_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh0001);
    queue_sample(16'sh8000, 16'sh8000, 16'shffff);
    queue_sample(16'sh0100, 16'sh00ff, 16'shff00);
    settle();

    // tap length just under the minimum
    cfg_write(REG_TAP_LENGTH, 16'd1000);
    cfg_write(REG_INPUT_GAIN, 16'd32768);
    cfg_write(REG_MIX_GAIN, 16'd16384);
    cfg_write(REG_FEEDBACK_GAIN, 16'd32768);
    queue_sample(16'sh7fff, '0, '0);
    queue_sample(16'sh8000, '0, '0);
    queue_sample(-16'sd3, 16'sd3, -16'sd3);
    queue_sample(16'sd3, -16'sd3, 16'sd3);
    settle();

    // short taps so tap two reaches recent data; middle chunk runs without gaps
    for (int c = 0; c < 3; c++) begin
      set_random_gains();
      cfg_write(REG_TAP_LENGTH, CFG_DATA_W'($urandom_range(TAP_MIN, TAP_MIN + 40)));
      in_gaps  = (c != 1);
      out_gaps = (c != 1);
      repeat (chunk_len[c]) queue_sample(pick_sample(), pick_sample(), pick_sample());
      settle();
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;

    // tap two and tap three on one location
    set_random_gains();
    cfg_write(REG_TAP_LENGTH, CFG_DATA_W'(OVERLAP_LEN_LO + 2 * $urandom_range(0, 2)));
    repeat (100) queue_sample(pick_sample(), pick_sample(), pick_sample());
    settle();

    // longest tap, full-scale input and mix, no feedback
    cfg_write(REG_INPUT_GAIN, 16'hffff);
    cfg_write(REG_MIX_GAIN, 16'hffff);
    cfg_write(REG_FEEDBACK_GAIN, 16'h0000);
    cfg_write(REG_TAP_LENGTH, 16'd16383);
    repeat (60) queue_sample(pick_sample(), pick_sample(), pick_sample());
    settle();

    // muted input, full feedback, tap length with stray upper bits
    cfg_write(REG_INPUT_GAIN, 16'h0000);
    cfg_write(REG_MIX_GAIN, 16'd32768);
    cfg_write(REG_FEEDBACK_GAIN, 16'hffff);
    cfg_write(REG_TAP_LENGTH, CFG_DATA_W'($urandom_range(0, 65535)));
    repeat (60) queue_sample(pick_sample(), pick_sample(), pick_sample());
    settle();

    // mix muted, random input and feedback, minimum tap
    cfg_write(REG_MIX_GAIN, 16'h0000);
    cfg_write(REG_INPUT_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(REG_FEEDBACK_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(REG_TAP_LENGTH, CFG_DATA_W'(TAP_MIN));
    repeat (40) queue_sample(pick_sample(), pick_sample(), pick_sample());
    settle();

    mismatch_cnt += expected_mix.size();
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
